FILE: sv/gbs_pkg.sv
// Shared types, codes and constants of the 3x3 Gaussian blur stream.
package gbs_pkg;

  localparam int MAX_WIDTH_DEF = 2048;

  localparam int PIX_BITS      = 8;
  localparam int IMG_W_BITS    = 12;
  localparam int IMG_H_BITS    = 16;
  localparam int WGT_BITS      = 12;
  localparam int FRAC_BITS     = 12;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int PIX_MAX       = 255;

  typedef logic [PIX_BITS-1:0]     pix_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  typedef logic [WGT_BITS-1:0]     wgt_t;

  // Configuration register indexes
  localparam cfg_idx_t CFG_IMAGE_WIDTH   = 3'd0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT  = 3'd1;
  localparam cfg_idx_t CFG_CORNER_WEIGHT = 3'd2;
  localparam cfg_idx_t CFG_EDGE_WEIGHT   = 3'd3;
  localparam cfg_idx_t CFG_CENTER_WEIGHT = 3'd4;

  // Register reset values
  localparam logic [IMG_W_BITS-1:0] RST_IMAGE_WIDTH   = 12'd2048;
  localparam logic [IMG_H_BITS-1:0] RST_IMAGE_HEIGHT  = 16'd1080;
  localparam wgt_t                  RST_CORNER_WEIGHT = 12'd312;
  localparam wgt_t                  RST_EDGE_WEIGHT   = 12'd451;
  localparam wgt_t                  RST_CENTER_WEIGHT = 12'd1044;

  // Input item kinds (tuser)
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Source of a result pixel
  typedef enum logic [1:0] {
    SEL_BLUR,
    SEL_CENTER,
    SEL_UPPER_B,
    SEL_LOWER_B
  } src_sel_t;

  // Decision taken for one accepted item
  typedef struct packed {
    logic     is_pixel;
    logic     emit;
    src_sel_t sel;
    logic     frame_last;
    pix_t     pixel;
  } issue_t;

  typedef struct packed {
    wgt_t corner;
    wgt_t side;
    wgt_t center;
  } weights_t;

endpackage

FILE: sv/gbs_line_ram.sv
// Line store: one write port, two registered read ports with same-edge write bypass.
module gbs_line_ram #(
  parameter int DEPTH = gbs_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  gbs_pkg::pix_t            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output gbs_pkg::pix_t            rdata_a,
  output gbs_pkg::pix_t            rdata_b
);
  import gbs_pkg::*;

  pix_t mem_r [DEPTH];
  pix_t rdata_a_r;
  pix_t rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Forward a write landing on the same edge as the read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= (we && (waddr == raddr_a)) ? wdata : mem_r[raddr_a];
      rdata_b_r <= (we && (waddr == raddr_b)) ? wdata : mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

FILE: sv/gbs_ctrl.sv
// Raster position, pending-result count and per-item decision with read addresses.
module gbs_ctrl #(
  parameter int MAX_WIDTH = gbs_pkg::MAX_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic                                 opcode,
  input  gbs_pkg::pix_t                        pixel,
  input  logic [gbs_pkg::IMG_W_BITS-1:0]       image_width,
  input  logic [gbs_pkg::IMG_H_BITS-1:0]       image_height,
  output gbs_pkg::issue_t                      issue,
  output logic [$clog2(MAX_WIDTH)-1:0]         addr_x,
  output logic [$clog2(MAX_WIDTH)-1:0]         addr_last,
  output logic [$clog2(MAX_WIDTH)-1:0]         addr_flush
);
  import gbs_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int LW = $clog2(MAX_WIDTH + 2);
  localparam int YW = IMG_H_BITS + 1;

  logic [AW-1:0]         col_r, col_nxt;
  logic [IMG_H_BITS-1:0] row_r, row_nxt;
  logic [LW-1:0]         pend_r, pend_nxt;

  logic [LW-1:0]         w;
  logic [LW-1:0]         wp1;
  logic [LW-1:0]         x;
  logic [LW-1:0]         pc;
  logic [IMG_H_BITS-1:0] h;
  logic [IMG_H_BITS-1:0] y;
  logic [YW-1:0]         y_step;

  always_comb begin
    // Effective frame size
    if (image_width == '0) begin
      w = LW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w = LW'(MAX_WIDTH);
    end else begin
      w = LW'(image_width);
    end
    wp1 = w + LW'(1);
    h   = (image_height == '0) ? IMG_H_BITS'(1) : image_height;

    // Position of this pixel; wrap on a shrunk size
    x      = LW'(col_r);
    y_step = {1'b0, row_r};
    if (x >= w) begin
      x      = '0;
      y_step = y_step + YW'(1);
    end
    if (y_step >= {1'b0, h}) begin
      x      = '0;
      y_step = '0;
    end
    y = y_step[IMG_H_BITS-1:0];

    pc = (pend_r > wp1) ? wp1 : pend_r;

    issue            = '0;
    issue.sel        = SEL_CENTER;
    issue.pixel      = pixel;
    col_nxt          = col_r;
    row_nxt          = row_r;
    pend_nxt         = pend_r;

    if (opcode == OP_FLUSH) begin
      if (pend_r != '0) begin
        issue.emit       = 1'b1;
        issue.sel        = (pc == wp1) ? SEL_UPPER_B : SEL_LOWER_B;
        issue.frame_last = (pc == LW'(1));
        pend_nxt         = pc - LW'(1);
      end
    end else begin
      issue.is_pixel = 1'b1;
      if ((x != '0) && (y != '0)) begin
        issue.emit = 1'b1;
        issue.sel  = ((x == LW'(1)) || (y == IMG_H_BITS'(1))) ? SEL_CENTER : SEL_BLUR;
      end else if ((x == '0) && (y >= IMG_H_BITS'(2))) begin
        issue.emit = 1'b1;
        issue.sel  = SEL_UPPER_B;
      end

      // Start of frame drops what the last frame left pending
      if ((x == '0) && (y == '0)) begin
        pend_nxt = '0;
      end

      if ((x + LW'(1)) >= w) begin
        col_nxt = '0;
        if (({1'b0, y} + YW'(1)) >= {1'b0, h}) begin
          row_nxt  = '0;
          pend_nxt = (y == '0) ? w : wp1;
        end else begin
          row_nxt = y + IMG_H_BITS'(1);
        end
      end else begin
        col_nxt = AW'(x + LW'(1));
        row_nxt = y;
      end
    end

    addr_x     = x[AW-1:0];
    addr_last  = AW'(w - LW'(1));
    addr_flush = AW'(w - pc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

FILE: sv/gbs_filter.sv
// Window, line-store write-back, weighted sum pipeline and output register.
module gbs_filter #(
  parameter int MAX_WIDTH = gbs_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  gbs_pkg::issue_t              issue,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr_x,
  input  gbs_pkg::weights_t            weights,
  input  gbs_pkg::pix_t                up_a,
  input  gbs_pkg::pix_t                up_b,
  input  gbs_pkg::pix_t                lo_a,
  input  gbs_pkg::pix_t                lo_b,
  output logic                         in_ready,
  output logic                         wr_en,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  output gbs_pkg::pix_t                up_wdata,
  output gbs_pkg::pix_t                lo_wdata,
  output logic                         out_valid,
  input  logic                         out_ready,
  output gbs_pkg::pix_t                out_pixel,
  output logic                         out_last
);
  import gbs_pkg::*;

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int SUM_W  = PIX_BITS + 2;
  localparam int PROD_W = WGT_BITS + SUM_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int RES_W  = ACC_W - FRAC_BITS;

  logic rdy1, rdy2, rdy3, rdy_o;
  logic s1_done;

  // Stage 1: read data in hand
  logic          s1_v_r;
  issue_t        s1_issue_r;
  logic [AW-1:0] s1_x_r;
  pix_t          win_r [3][2];

  logic [SUM_W-1:0] corners, sides;
  pix_t             center, pass;

  // Stage 2: sums
  logic             s2_v_r;
  logic             s2_blur_r;
  logic             s2_last_r;
  pix_t             s2_pass_r;
  pix_t             s2_center_r;
  logic [SUM_W-1:0] s2_corners_r, s2_sides_r;

  // Stage 3: products
  logic              s3_v_r;
  logic              s3_blur_r;
  logic              s3_last_r;
  pix_t              s3_pass_r;
  logic [PROD_W-1:0] prod_c_r, prod_s_r, prod_m_r;

  logic [ACC_W-1:0]  acc;
  logic [RES_W-1:0]  scaled;
  pix_t              blurred;

  // Output register
  logic out_v_r;
  pix_t out_pix_r;
  logic out_last_r;

  assign rdy_o    = !out_v_r || out_ready;
  assign rdy3     = !s3_v_r || rdy_o;
  assign rdy2     = !s2_v_r || rdy3;
  assign rdy1     = !s1_v_r || rdy2;
  assign in_ready = rdy1;
  assign s1_done  = s1_v_r && rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_issue_r <= issue;
      s1_x_r     <= addr_x;
    end
  end

  always_comb begin
    corners = SUM_W'(win_r[0][0]) + SUM_W'(up_a) + SUM_W'(win_r[2][0])
            + SUM_W'(s1_issue_r.pixel);
    sides   = SUM_W'(win_r[0][1]) + SUM_W'(win_r[1][0]) + SUM_W'(lo_a)
            + SUM_W'(win_r[2][1]);
    center  = win_r[1][1];
    case (s1_issue_r.sel)
      SEL_UPPER_B: pass = up_b;
      SEL_LOWER_B: pass = lo_b;
      default:     pass = center;
    endcase
  end

  // Write back: the row above moves up, the new pixel fills the row below
  assign wr_en    = s1_done && s1_issue_r.is_pixel;
  assign wr_addr  = s1_x_r;
  assign up_wdata = lo_a;
  assign lo_wdata = s1_issue_r.pixel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= '0;
        win_r[r][1] <= '0;
      end
    end else if (wr_en) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
      end
      win_r[0][1] <= up_a;
      win_r[1][1] <= lo_a;
      win_r[2][1] <= s1_issue_r.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy2) begin
      s2_v_r <= s1_v_r && s1_issue_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done) begin
      s2_blur_r    <= (s1_issue_r.sel == SEL_BLUR);
      s2_last_r    <= s1_issue_r.frame_last;
      s2_pass_r    <= pass;
      s2_center_r  <= center;
      s2_corners_r <= corners;
      s2_sides_r   <= sides;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (rdy3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_v_r) begin
      prod_c_r  <= PROD_W'(weights.corner) * PROD_W'(s2_corners_r);
      prod_s_r  <= PROD_W'(weights.side) * PROD_W'(s2_sides_r);
      prod_m_r  <= PROD_W'(weights.center) * PROD_W'(s2_center_r);
      s3_blur_r <= s2_blur_r;
      s3_last_r <= s2_last_r;
      s3_pass_r <= s2_pass_r;
    end
  end

  // Truncate once, then saturate
  always_comb begin
    acc     = ACC_W'(prod_c_r) + ACC_W'(prod_s_r) + ACC_W'(prod_m_r);
    scaled  = acc[ACC_W-1:FRAC_BITS];
    blurred = (scaled > RES_W'(PIX_MAX)) ? PIX_BITS'(PIX_MAX) : scaled[PIX_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy_o) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && s3_v_r) begin
      out_pix_r  <= s3_blur_r ? blurred : s3_pass_r;
      out_last_r <= s3_last_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_pixel = out_pix_r;
  assign out_last  = out_last_r;

endmodule

FILE: sv/gaussian_blur_3x3_stream.sv
// Top level of the streaming 3x3 Gaussian blur on 8-bit grayscale pixels.
//
// Usage:
//   in_*   : one transfer per pixel in raster order (tuser = 0) or per flush
//            item (tuser = 1, tdata ignored). Flush items drain the last row
//            of a frame after its final pixel; a flush with nothing pending
//            produces nothing.
//   out_*  : result pixels in raster order; tlast marks the final pixel of a
//            frame, which always leaves on a flush.
//   cfg_*  : write a register (width, height, corner, edge, center weight)
//            while the block is idle; a write takes effect at once.
// Throughput: one input transfer per clock while the output does not stall.
//   Each pixel transfer does one read-modify-write on the two line stores,
//   so the port pair sets the rate; a write on a read's edge is forwarded.
// Pipeline: a result is registered through the read, sum, product and output
//   registers; in image terms results trail the input by one row plus one
//   pixel. Border pixels pass through, interior pixels are blurred.
// Reset: counters, window and pipeline clear; the line stores are not
//   cleared (every entry is written before it is read in a frame).
// Stall: a stalled receiver holds the output register; the input side keeps
//   taking transfers until the three pipeline stages behind it are full.
module gaussian_blur_3x3_stream #(
  parameter int MAX_WIDTH = gbs_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  gbs_pkg::pix_t                       in_tdata,   // [7:0] pixel_in
  input  logic                                in_tuser,   // [0] opcode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output gbs_pkg::pix_t                       out_tdata,  // [7:0] pixel_out
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  gbs_pkg::cfg_idx_t                   cfg_index,
  input  logic [gbs_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
  import gbs_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic [IMG_W_BITS-1:0] img_w_r;
  logic [IMG_H_BITS-1:0] img_h_r;
  wgt_t                  corner_w_r, edge_w_r, center_w_r;
  weights_t              weights;

  logic          accept;
  issue_t        issue;
  logic [AW-1:0] addr_x, addr_last, addr_flush;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  pix_t          up_wdata, lo_wdata;
  pix_t          up_a, up_b, lo_a, lo_b;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r    <= RST_IMAGE_WIDTH;
      img_h_r    <= RST_IMAGE_HEIGHT;
      corner_w_r <= RST_CORNER_WEIGHT;
      edge_w_r   <= RST_EDGE_WEIGHT;
      center_w_r <= RST_CENTER_WEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:   img_w_r    <= cfg_wdata[IMG_W_BITS-1:0];
        CFG_IMAGE_HEIGHT:  img_h_r    <= cfg_wdata[IMG_H_BITS-1:0];
        CFG_CORNER_WEIGHT: corner_w_r <= cfg_wdata[WGT_BITS-1:0];
        CFG_EDGE_WEIGHT:   edge_w_r   <= cfg_wdata[WGT_BITS-1:0];
        CFG_CENTER_WEIGHT: center_w_r <= cfg_wdata[WGT_BITS-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign weights = '{corner: corner_w_r, side: edge_w_r, center: center_w_r};

  assign accept = in_tvalid && in_tready;

  // Position tracking and read-address generation for each transfer
  gbs_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .opcode       (in_tuser),
    .pixel        (in_tdata),
    .image_width  (img_w_r),
    .image_height (img_h_r),
    .issue        (issue),
    .addr_x       (addr_x),
    .addr_last    (addr_last),
    .addr_flush   (addr_flush)
  );

  // Row two above: port A at the current column, port B at the last column
  gbs_line_ram #(
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (up_wdata),
    .re      (accept),
    .raddr_a (addr_x),
    .raddr_b (addr_last),
    .rdata_a (up_a),
    .rdata_b (up_b)
  );

  // Row just above: port A at the current column, port B at the flush slot
  gbs_line_ram #(
    .DEPTH (MAX_WIDTH)
  ) u_lower (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (lo_wdata),
    .re      (accept),
    .raddr_a (addr_x),
    .raddr_b (addr_flush),
    .rdata_a (lo_a),
    .rdata_b (lo_b)
  );

  gbs_filter #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .issue     (issue),
    .addr_x    (addr_x),
    .weights   (weights),
    .up_a      (up_a),
    .up_b      (up_b),
    .lo_a      (lo_a),
    .lo_b      (lo_b),
    .in_ready  (in_tready),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .up_wdata  (up_wdata),
    .lo_wdata  (lo_wdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pixel (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

FILE: sv/gbs_checker.sv
// Port-level checker of the blur stream and its bind to the top level.
module gbs_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_tvalid,
  input logic          in_tready,
  input logic          out_tvalid,
  input logic          out_tready,
  input gbs_pkg::pix_t out_tdata,
  input logic          out_tlast
);
  import gbs_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed or dropped");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // An empty output register leaves room upstream
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // A full pipeline stays full while the receiver keeps stalling
  a_full_stays: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && !in_tready |=> out_tready || !in_tready)
    else $error("input opened without any transfer out");

endmodule

bind gaussian_blur_3x3_stream gbs_checker u_gbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

FILE: dv/blur_stream_checker.sv
`timescale 1ns / 100ps
// Checker for the blur stream: predicts every result transfer and compares it.
module blur_stream_checker #(
  parameter int MAX_WIDTH = gbs_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  gbs_pkg::pix_t                     in_tdata,
  input  logic                              in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  gbs_pkg::pix_t                     out_tdata,
  input  logic                              out_tlast,
  input  logic                              cfg_we,
  input  gbs_pkg::cfg_idx_t                 cfg_index,
  input  logic [gbs_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  output int                                fail_count,
  output int                                open_results
);
  import gbs_pkg::*;

  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int PEND_BITS   = COL_BITS + 1;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    pix_t pixel;
    logic frame_last;
  } blur_result_t;

  blur_result_t expected_pixels[$];

  logic [IMG_W_BITS-1:0] width_reg;
  logic [IMG_H_BITS-1:0] height_reg;
  wgt_t                  corner_w;
  wgt_t                  side_w;
  wgt_t                  center_w;

  pix_t                  upper_line [MAX_WIDTH];
  pix_t                  lower_line [MAX_WIDTH];
  pix_t                  win [3][3];
  logic [COL_BITS-1:0]   col_pos;
  logic [IMG_H_BITS-1:0] row_pos;
  logic [PEND_BITS-1:0]  pending_cnt;
  int                    failures = 0;

  // Weighted 3x3 sum, truncated once and clipped to the pixel range.
  function automatic pix_t blur_center();
    int corners, sides, acc;
    corners = int'(win[0][0]) + int'(win[0][2]) + int'(win[2][0]) + int'(win[2][2]);
    sides   = int'(win[0][1]) + int'(win[1][0]) + int'(win[1][2]) + int'(win[2][1]);
    acc = int'(corner_w) * corners + int'(side_w) * sides + int'(center_w) * int'(win[1][1]);
    acc = acc >> FRAC_BITS;
    return (acc > PIX_MAX) ? pix_t'(PIX_MAX) : pix_t'(acc);
  endfunction

  // Advance the raster state by one accepted item and queue what it produces.
  function automatic void predict_blur_item(input logic op, input pix_t pix);
    int   w, h, x, y, pend;
    pix_t corner_above, above2, above1, v;
    logic emit;
    w = (width_reg == '0) ? 1 :
        (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    h = (height_reg == '0) ? 1 : int'(height_reg);

    if (op == OP_FLUSH) begin
      pend = int'(pending_cnt);
      if (pend == 0) return;
      if (pend > w + 1) pend = w + 1;
      v = (pend == w + 1) ? upper_line[w - 1] : lower_line[w - pend];
      pend--;
      pending_cnt = PEND_BITS'(pend);
      expected_pixels.push_back('{pixel: v, frame_last: (pend == 0)});
      return;
    end

    // wrap position if the size shrank under the counters
    x = int'(col_pos);
    y = int'(row_pos);
    if (x >= w) begin
      x = 0;
      y++;
    end
    if (y >= h) begin
      x = 0;
      y = 0;
    end
    if (x == 0 && y == 0) pending_cnt = '0;

    corner_above  = upper_line[w - 1];
    above2        = upper_line[x];
    above1        = lower_line[x];
    upper_line[x] = above1;
    lower_line[x] = pix;

    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = above2;
    win[1][2] = above1;
    win[2][2] = pix;

    emit = 1'b0;
    v    = '0;
    if (x >= 1 && y >= 1) begin
      emit = 1'b1;
      v    = (x == 1 || y == 1) ? win[1][1] : blur_center();
    end else if (x == 0 && y >= 2) begin
      emit = 1'b1;
      v    = corner_above;
    end

    if (x + 1 >= w) begin
      col_pos = '0;
      if (y + 1 >= h) begin
        row_pos     = '0;
        pending_cnt = PEND_BITS'((y == 0) ? w : w + 1);
      end else begin
        row_pos = IMG_H_BITS'(y + 1);
      end
    end else begin
      col_pos = COL_BITS'(x + 1);
      row_pos = IMG_H_BITS'(y);
    end

    if (emit) expected_pixels.push_back('{pixel: v, frame_last: 1'b0});
  endfunction

  always @(posedge clk) begin
    blur_result_t want;
    if (!rst_n) begin
      width_reg  = RST_IMAGE_WIDTH;
      height_reg = RST_IMAGE_HEIGHT;
      corner_w   = RST_CORNER_WEIGHT;
      side_w     = RST_EDGE_WEIGHT;
      center_w   = RST_CENTER_WEIGHT;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] = '0;
        end
      end
      col_pos     = '0;
      row_pos     = '0;
      pending_cnt = '0;
      expected_pixels.delete();
    end else begin
      // compare before queuing: no result leaves in the cycle of its input
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("%0t: unexpected result transfer: pixel %0d last %0b",
                     $time, out_tdata, out_tlast);
        end else begin
          want = expected_pixels.pop_front();
          if (out_tdata !== want.pixel || out_tlast !== want.frame_last) begin
            failures++;
            if (failures <= MAX_REPORTS)
              $display("%0t: result mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                       $time, want.pixel, want.frame_last, out_tdata, out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready) predict_blur_item(in_tuser, in_tdata);
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:   width_reg  = cfg_wdata[IMG_W_BITS-1:0];
          CFG_IMAGE_HEIGHT:  height_reg = cfg_wdata[IMG_H_BITS-1:0];
          CFG_CORNER_WEIGHT: corner_w   = cfg_wdata[WGT_BITS-1:0];
          CFG_EDGE_WEIGHT:   side_w     = cfg_wdata[WGT_BITS-1:0];
          CFG_CENTER_WEIGHT: center_w   = cfg_wdata[WGT_BITS-1:0];
          default: ;
        endcase
      end
    end
    open_results <= expected_pixels.size();
    fail_count   <= failures;
  end

endmodule

FILE: dv/tb_gaussian_blur_3x3_stream.sv
`timescale 1ns / 100ps
// Testbench top for the 3x3 Gaussian blur stream: stimulus, idling and verdict.
module tb_gaussian_blur_3x3_stream;
  import gbs_pkg::*;

  // Idling profiles; each frame runs under one of them.
  localparam int MODE_STEADY     = 0;
  localparam int MODE_SRC_IDLE   = 1;
  localparam int MODE_SINK_STALL = 2;
  localparam int MODE_BOTH       = 3;
  localparam int SRC_IDLE_PCT    = 54;
  localparam int SINK_STALL_PCT  = 54;
  localparam int BOTH_PCT        = 28;

  // Random frame shapes besides the plain fully flushed one.
  localparam int SHAPE_CUT       = 0;  // drain only part of the last row
  localparam int SHAPE_NOISY     = 1;  // stray flushes between pixels
  localparam int SHAPE_OVERRUN   = 2;  // extra flushes after the drain

  localparam int RANDOM_ITEMS    = 520;
  localparam int DRAIN_GAP       = 8;      // wait past the four pipeline registers
  localparam int SETTLE_LIMIT    = 20000;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  pix_t                     in_tdata   = '0;
  logic                     in_tuser   = OP_PIXEL;
  logic                     out_tready = 1'b0;
  logic                     cfg_we     = 1'b0;
  cfg_idx_t                 cfg_index  = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_BITS-1:0] cfg_wdata  = '0;
  logic                     in_tready;
  logic                     out_tvalid;
  pix_t                     out_tdata;
  logic                     out_tlast;
  int                       fail_count;
  int                       open_results;

  int idle_mode  = MODE_STEADY;
  int load_items = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  gaussian_blur_3x3_stream u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  blur_stream_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .open_results (open_results)
  );

  // Receiver: stall at random under the stalling profiles, stay ready otherwise.
  always @(posedge clk) begin
    case (idle_mode)
      MODE_SINK_STALL: out_tready <= ($urandom_range(0, 99) >= SINK_STALL_PCT);
      MODE_BOTH:       out_tready <= ($urandom_range(0, 99) >= BOTH_PCT);
      default:         out_tready <= 1'b1;
    endcase
  end

  // Bias pixels toward the range ends so saturation and zero sums show up.
  function automatic pix_t rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Weights near a typical kernel half the time, else the register extremes or a random value.
  function automatic int pick_weight(input int typical);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 4095;
      2:       return int'($urandom_range(0, 4095));
      default: return int'($urandom_range(typical / 2, typical * 3 / 2));
    endcase
  endfunction

  // Offer one item; hold it until the transfer happens. Insert idle cycles
  // ahead of it under the sender-idle profiles.
  task automatic push_item(input logic op, input pix_t pix);
    int idle_pct;
    idle_pct = (idle_mode == MODE_SRC_IDLE) ? SRC_IDLE_PCT :
               (idle_mode == MODE_BOTH)     ? BOTH_PCT     : 0;
    while (int'($urandom_range(0, 99)) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_pixels(input int count);
    for (int i = 0; i < count; i++) push_item(OP_PIXEL, rand_pixel());
  endtask

  // Flush items carry junk in tdata; the block must ignore it.
  task automatic send_flushes(input int count);
    for (int i = 0; i < count; i++) push_item(OP_FLUSH, rand_pixel());
  endtask

  // Drop valid and wait until every predicted result has left, then give
  // items that produce nothing time to clear the pipeline.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // Write all five registers back to back, one per cycle.
  task automatic program_regs(input int wdt, input int hgt, input int cw, input int ew,
                              input int mw);
    cfg_idx_t idx [5];
    int       vals [5];
    idx  = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_CORNER_WEIGHT, CFG_EDGE_WEIGHT,
             CFG_CENTER_WEIGHT};
    vals = '{wdt, hgt, cw, ew, mw};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= CFG_DATA_BITS'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Stimulus. Store entries are only read back once written: mid-frame size
  // changes and clamped drains only ever shrink into columns already filled.
  initial begin
    int fw, fh, flush_due, shape, frame_no, wait_cycles;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Width and height zero act as one: a single-pixel frame drains through
    // one flush; the second flush finds nothing pending.
    program_regs(0, 0, int'(RST_CORNER_WEIGHT), int'(RST_EDGE_WEIGHT),
                 int'(RST_CENTER_WEIGHT));
    push_item(OP_PIXEL, 8'hA5);
    send_flushes(2);
    settle();

    // Full weights on a bright frame saturate the one interior pixel. A flush
    // mid-frame with nothing pending must be ignored.
    idle_mode = MODE_BOTH;
    program_regs(3, 3, 4095, 4095, 4095);
    for (int i = 0; i < 9; i++) begin
      push_item(OP_PIXEL, (i == 8) ? 8'h00 : 8'hFF);
      if (i == 2) push_item(OP_FLUSH, 8'h3C);
    end
    send_flushes(4);
    settle();

    // Leave a frame undrained, shrink the width so the pending count clamps,
    // drain one, then start a new frame that drops the rest. Zero weights.
    idle_mode = MODE_SRC_IDLE;
    program_regs(3, 2, int'(RST_CORNER_WEIGHT), int'(RST_EDGE_WEIGHT),
                 int'(RST_CENTER_WEIGHT));
    send_pixels(6);
    settle();
    program_regs(1, 2, int'(RST_CORNER_WEIGHT), int'(RST_EDGE_WEIGHT),
                 int'(RST_CENTER_WEIGHT));
    send_flushes(1);
    settle();
    program_regs(3, 3, 0, 0, 0);
    send_pixels(9);
    send_flushes(4);
    settle();

    // Narrow the frame mid-row: the column count past the new width opens a
    // new row.
    idle_mode = MODE_SINK_STALL;
    program_regs(3, 4, int'(RST_CORNER_WEIGHT), int'(RST_EDGE_WEIGHT),
                 int'(RST_CENTER_WEIGHT));
    send_pixels(8);
    settle();
    program_regs(2, 4, int'(RST_CORNER_WEIGHT), int'(RST_EDGE_WEIGHT),
                 int'(RST_CENTER_WEIGHT));
    send_pixels(2);
    send_flushes(3);
    settle();

    // Maximum height, then cut it mid-frame: the row count past the new
    // height restarts at the origin.
    idle_mode = MODE_STEADY;
    program_regs(2, 65535, pick_weight(int'(RST_CORNER_WEIGHT)),
                 pick_weight(int'(RST_EDGE_WEIGHT)), pick_weight(int'(RST_CENTER_WEIGHT)));
    send_pixels(6);
    settle();
    program_regs(2, 2, pick_weight(int'(RST_CORNER_WEIGHT)),
                 pick_weight(int'(RST_EDGE_WEIGHT)), pick_weight(int'(RST_CENTER_WEIGHT)));
    send_pixels(4);
    send_flushes(3);

    // Random frames, mostly small, each under the next idling profile.
    frame_no = 0;
    while (load_items < RANDOM_ITEMS) begin
      idle_mode = frame_no % 4;
      fw        = ($urandom_range(0, 7) == 0) ? int'($urandom_range(13, 40))
                                              : int'($urandom_range(1, 12));
      fh        = int'($urandom_range(1, 6));
      flush_due = (fh == 1) ? fw : fw + 1;
      shape     = int'($urandom_range(0, 9));
      settle();
      program_regs(fw, fh, pick_weight(int'(RST_CORNER_WEIGHT)),
                   pick_weight(int'(RST_EDGE_WEIGHT)), pick_weight(int'(RST_CENTER_WEIGHT)));
      for (int i = 0; i < fw * fh; i++) begin
        // stray flushes only after the first pixel, once pending is cleared
        if (shape == SHAPE_NOISY && i > 0 && $urandom_range(0, 5) == 0)
          push_item(OP_FLUSH, rand_pixel());
        push_item(OP_PIXEL, rand_pixel());
      end
      if (shape == SHAPE_CUT) flush_due = int'($urandom_range(0, flush_due - 1));
      send_flushes(flush_due);
      if (shape == SHAPE_OVERRUN) send_flushes(2);
      load_items += fw * fh + flush_due;
      frame_no++;
    end

    // Drain: wait for the last expected result, bounded, then a short tail
    // so a surplus result would still be caught.
    in_tvalid <= 1'b0;
    @(posedge clk);
    for (wait_cycles = 0; open_results != 0 && wait_cycles < SETTLE_LIMIT; wait_cycles++)
      @(posedge clk);
    repeat (2 * DRAIN_GAP) @(posedge clk);

    if (fail_count == 0 && open_results == 0) begin
      $display("PASS gaussian_blur_3x3_stream");
    end else begin
      $display("FAIL gaussian_blur_3x3_stream");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("FAIL gaussian_blur_3x3_stream");
    $finish;
  end

endmodule
